FILE: rtl/swsnd_pkg.sv
// Shared types and codes of the sliding window sender.
// Depends on nothing; every other file of the block imports it.
package swsnd_pkg;

   // Item kinds as they arrive on the request channel
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_ACK    = 2'd1;
   localparam logic [1:0] OP_HSDONE = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   // Result events
   localparam logic [2:0] EV_SEND      = 3'd0;
   localparam logic [2:0] EV_RESEND    = 3'd1;
   localparam logic [2:0] EV_HANDSHAKE = 3'd2;
   localparam logic [2:0] EV_EARLY     = 3'd3;
   localparam logic [2:0] EV_DONE      = 3'd4;

   // Transfer phases
   localparam logic [1:0] PH_CLOSED   = 2'd0;
   localparam logic [1:0] PH_HANDSHK  = 2'd1;
   localparam logic [1:0] PH_TRANSFER = 2'd2;

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = 1;

   typedef struct packed {
      logic [15:0] packet_count;
      logic [10:0] last_len;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] ack_seq;
      logic        seq_in_count;   // ack_seq below packet_count
   } cmd_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] packet_seq;
      logic [10:0] data_len;
   } result_type;

endpackage

FILE: rtl/swsnd_front.sv
// Front end of the sliding window sender: takes request beats and classifies them.
// Depends on swsnd_pkg; feeds swsnd_cmdq.
module swsnd_front (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            kind,
   input  logic [15:0]           ack_seq,
   input  swsnd_pkg::cfg_type    cfg,
   input  logic                  q_full,
   output logic                  q_push,
   output swsnd_pkg::cmd_type    q_cmd
);
   import swsnd_pkg::*;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // An ack at or beyond the packet count can never be valid; flag it here.
   always_comb begin
      q_cmd.op           = kind;
      q_cmd.ack_seq      = ack_seq;
      q_cmd.seq_in_count = (kind == OP_ACK) && (ack_seq < cfg.packet_count);
   end

endmodule

FILE: rtl/swsnd_cmdq.sv
// Short command queue that decouples the front end from the sequencer.
// Depends on swsnd_pkg.
module swsnd_cmdq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  swsnd_pkg::cmd_type    push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output swsnd_pkg::cmd_type    head_cmd
);
   import swsnd_pkg::*;

   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type              entry_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/swsnd_back.sv
// Back end of the sliding window sender: window state, per-slot timers and
// the sequencer that produces result beats. Depends on swsnd_pkg.
module swsnd_back #(
   parameter int WINDOW_SLOTS  = 8,
   parameter int PAYLOAD_BYTES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swsnd_pkg::cfg_type    cfg,
   input  logic                  q_not_empty,
   input  swsnd_pkg::cmd_type    q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output swsnd_pkg::result_type rsp_res,
   output logic                  rsp_last
);
   import swsnd_pkg::*;

   localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int IDX_W  = $clog2(WINDOW_SLOTS + 1);
   localparam logic [10:0] FULL_LEN = 11'(PAYLOAD_BYTES % 2048);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SLIDE = 3'd1;
   localparam logic [2:0] ST_HSEND = 3'd2;
   localparam logic [2:0] ST_TICK  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              phase_ff, phase_in;
   logic [15:0]             base_ff, base_in;
   logic [IDX_W-1:0]        bslot_ff, bslot_in;
   logic [WINDOW_SLOTS-1:0] acked_ff, acked_in;
   logic [WINDOW_SLOTS-1:0] outst_ff, outst_in;
   logic [15:0]             age_ff [WINDOW_SLOTS];
   logic [15:0]             age_in [WINDOW_SLOTS];
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic                    pend_valid_ff, pend_valid_in;
   result_type              pend_ff, pend_in;
   logic                    out_valid_ff, out_valid_in;
   result_type              out_ff, out_in;
   logic                    out_last_ff, out_last_in;

   logic                    step;
   logic                    gen_valid;
   result_type              gen;
   logic                    flush;
   logic [16:0]             base_plus_w;
   logic [16:0]             ack_diff;
   logic [IDX_W:0]          ack_sum;
   logic [SLOT_W-1:0]       ack_slot;
   logic                    ack_in_win;
   logic [SLOT_W-1:0]       bslot_idx;
   logic [SLOT_W-1:0]       tick_idx;
   logic [IDX_W:0]          tick_off;
   logic [16:0]             tick_seq;
   logic [15:0]             aged;

   function automatic logic [10:0] length_of(input logic [16:0] seq,
                                             input cfg_type c,
                                             input logic [10:0] full_len);
      logic [10:0] len;
      if (c.packet_count != '0 && seq == {1'b0, c.packet_count - 16'd1}) begin
         len = c.last_len;
      end else begin
         len = full_len;
      end
      return len;
   endfunction

   // The sequencer moves only when the output register can take a beat.
   assign step = !out_valid_ff || rsp_ready;

   assign base_plus_w = {1'b0, base_ff} + 17'(WINDOW_SLOTS);
   assign ack_diff    = {1'b0, q_cmd.ack_seq} - {1'b0, base_ff};
   assign ack_in_win  = (q_cmd.ack_seq >= base_ff) && ({1'b0, q_cmd.ack_seq} < base_plus_w);
   assign ack_sum     = {1'b0, bslot_ff} + {1'b0, ack_diff[IDX_W-1:0]};
   assign ack_slot    = (ack_sum >= (IDX_W+1)'(WINDOW_SLOTS))
                        ? SLOT_W'(ack_sum - (IDX_W+1)'(WINDOW_SLOTS))
                        : SLOT_W'(ack_sum);
   assign bslot_idx   = SLOT_W'(bslot_ff);
   assign tick_idx    = SLOT_W'(cnt_ff);
   assign tick_off    = (cnt_ff >= bslot_ff)
                        ? {1'b0, cnt_ff} - {1'b0, bslot_ff}
                        : {1'b0, cnt_ff} + (IDX_W+1)'(WINDOW_SLOTS) - {1'b0, bslot_ff};
   assign tick_seq    = {1'b0, base_ff} + 17'(tick_off);
   assign aged        = (age_ff[tick_idx] == 16'hFFFF) ? 16'hFFFF : age_ff[tick_idx] + 16'd1;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      base_in   = base_ff;
      bslot_in  = bslot_ff;
      acked_in  = acked_ff;
      outst_in  = outst_ff;
      age_in    = age_ff;
      cnt_in    = cnt_ff;
      gen_valid = 1'b0;
      gen       = '0;
      flush     = 1'b0;
      q_pop     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (step && q_not_empty) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_START: begin
                     base_in   = '0;
                     bslot_in  = '0;
                     acked_in  = '0;
                     outst_in  = '0;
                     for (int i = 0; i < WINDOW_SLOTS; i++) begin
                        age_in[i] = '0;
                     end
                     phase_in  = PH_HANDSHK;
                     gen_valid = 1'b1;
                     gen       = '{EV_HANDSHAKE, cfg.packet_count, 11'd0};
                     state_in  = ST_FLUSH;
                  end
                  OP_ACK: begin
                     if (phase_ff == PH_HANDSHK) begin
                        gen_valid = 1'b1;
                        gen       = '{EV_EARLY, q_cmd.ack_seq, 11'd0};
                        state_in  = ST_FLUSH;
                     end else if (phase_ff == PH_TRANSFER && q_cmd.seq_in_count &&
                                  ack_in_win && !acked_ff[ack_slot]) begin
                        acked_in[ack_slot] = 1'b1;
                        state_in           = ST_SLIDE;
                     end
                  end
                  OP_HSDONE: begin
                     if (phase_ff != PH_CLOSED) begin
                        base_in  = '0;
                        bslot_in = '0;
                        acked_in = '0;
                        outst_in = '0;
                        for (int i = 0; i < WINDOW_SLOTS; i++) begin
                           age_in[i] = '0;
                        end
                        phase_in = PH_TRANSFER;
                        cnt_in   = '0;
                        state_in = ST_HSEND;
                     end
                  end
                  OP_TICK: begin
                     if (phase_ff != PH_CLOSED) begin
                        cnt_in   = '0;
                        state_in = ST_TICK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SLIDE: begin
            if (step) begin
               if (!acked_ff[bslot_idx]) begin
                  if (base_ff == cfg.packet_count) begin
                     phase_in  = PH_CLOSED;
                     gen_valid = 1'b1;
                     gen       = '{EV_DONE, cfg.packet_count, 11'd0};
                  end
                  state_in = ST_FLUSH;
               end else begin
                  // The packet admitted at the top lands in the slot just freed.
                  acked_in[bslot_idx] = 1'b0;
                  age_in[bslot_idx]   = '0;
                  if (base_plus_w < {1'b0, cfg.packet_count}) begin
                     outst_in[bslot_idx] = 1'b1;
                     gen_valid           = 1'b1;
                     gen = '{EV_SEND, base_plus_w[15:0], length_of(base_plus_w, cfg, FULL_LEN)};
                  end else begin
                     outst_in[bslot_idx] = 1'b0;
                  end
                  base_in  = base_ff + 16'd1;
                  bslot_in = (bslot_ff == IDX_W'(WINDOW_SLOTS - 1)) ? '0 : bslot_ff + 1'b1;
               end
            end
         end
         ST_HSEND: begin
            if (step) begin
               if (cnt_ff < IDX_W'(WINDOW_SLOTS) && 16'(cnt_ff) < cfg.packet_count) begin
                  outst_in[tick_idx] = 1'b1;
                  gen_valid          = 1'b1;
                  gen = '{EV_SEND, 16'(cnt_ff), length_of(17'(cnt_ff), cfg, FULL_LEN)};
                  cnt_in             = cnt_ff + 1'b1;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_TICK: begin
            if (step) begin
               if (outst_ff[tick_idx]) begin
                  if (aged > cfg.timeout_ticks) begin
                     age_in[tick_idx] = '0;
                     gen_valid        = 1'b1;
                     gen = '{EV_RESEND, tick_seq[15:0], length_of(tick_seq, cfg, FULL_LEN)};
                  end else begin
                     age_in[tick_idx] = aged;
                  end
               end
               if (cnt_ff == IDX_W'(WINDOW_SLOTS - 1)) begin
                  state_in = ST_FLUSH;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (step) begin
               flush    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // A new result pushes the held one out as not last; the end of an item
   // releases the held one marked last.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      if (step) begin
         out_valid_in = 1'b0;
         if (gen_valid) begin
            pend_valid_in = 1'b1;
            pend_in       = gen;
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_in       = pend_ff;
               out_last_in  = 1'b0;
            end
         end else if (flush) begin
            pend_valid_in = 1'b0;
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_in       = pend_ff;
               out_last_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_CLOSED;
         base_ff       <= '0;
         bslot_ff      <= '0;
         acked_ff      <= '0;
         outst_ff      <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < WINDOW_SLOTS; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         base_ff       <= base_in;
         bslot_ff      <= bslot_in;
         acked_ff      <= acked_in;
         outst_ff      <= outst_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         age_ff        <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_ff;
   assign rsp_last  = out_last_ff;

endmodule

FILE: rtl/sliding_window_sender.sv
// Top level of the selective-repeat sliding window sender (control path).
// Depends on swsnd_pkg, swsnd_front, swsnd_cmdq and swsnd_back.
//
//   Channel  Direction  Contents
//   req_     in         tuser = kind, tdata = ack_seq
//   rsp_     out        tuser = event_res, tdata = packet_seq, data_len; tlast
//   csr_     in         write enable, register index, write data
//
// A request beat is taken whenever the two-entry command queue has room, so the
// front end keeps accepting while the sequencer or the output register is busy.
// The sequencer takes one command from the queue; a dropped or ignored item ends
// there. Otherwise it steps through the window (each slid slot and then a stop
// check on an ack, each packet sent and then a stop check on handshake done,
// each of the WINDOW_SLOTS slots on a tick, no step on a start or an early ack)
// and then releases the last beat, stalling while rsp_tready is held low. Reset
// is synchronous and clears the window, the timers, the queue and the output
// register; the registers return to their defaults.
module sliding_window_sender #(
   parameter int WINDOW_SLOTS  = 8,
   parameter int PAYLOAD_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] ack_seq
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] packet_seq, [26:16] data_len, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] event_res
   output logic        rsp_tlast,   // last_of_run
   // configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import swsnd_pkg::*;

   // Register indexes of the configuration port
   localparam logic [1:0] REG_PACKET_COUNT = 2'd0;
   localparam logic [1:0] REG_LAST_LEN     = 2'd1;
   localparam logic [1:0] REG_TIMEOUT      = 2'd2;

   cfg_type    cfg_ff, cfg_in;
   logic       q_full, q_push, q_pop, q_not_empty;
   cmd_type    push_cmd, head_cmd;
   result_type rsp_res;

   // Configuration registers. A write to an index beyond the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PACKET_COUNT: cfg_in.packet_count  = csr_wdata;
            REG_LAST_LEN:     cfg_in.last_len      = csr_wdata[10:0];
            REG_TIMEOUT:      cfg_in.timeout_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_count  <= 16'd1;
         cfg_ff.last_len      <= 11'd1024;
         cfg_ff.timeout_ticks <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies each beat and queues it as a command.
   swsnd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .kind       (req_tuser),
      .ack_seq    (req_tdata),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   swsnd_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // The back end owns the window and timers and drives the result channel
   // from its own output register.
   swsnd_back #(
      .WINDOW_SLOTS  (WINDOW_SLOTS),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_res     (rsp_res),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, rsp_res.data_len, rsp_res.packet_seq};
   assign rsp_tuser = rsp_res.event_res;

endmodule

FILE: tb/sv/sliding_window_sender_tb.sv
// Self-checking testbench for the sliding window sender control path.
// Depends on swsnd_pkg and the sliding_window_sender RTL; nothing else is read.
// Result beats are predicted from the request beats by a private window model and every result beat is checked.
`timescale 1ns / 100ps

module sliding_window_sender_tb;
   import swsnd_pkg::*;

   localparam int SLOTS    = 8;
   localparam int FULL_LEN = 1024;

   // Wait after the last expected beat for items that produce nothing
   // (two queued commands plus the one in the sequencer).
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 300;
   localparam int unsigned CYCLE_LIMIT = 400000;

   localparam logic [1:0] REG_PACKET_COUNT = 2'd0;
   localparam logic [1:0] REG_LAST_LEN     = 2'd1;
   localparam logic [1:0] REG_TIMEOUT      = 2'd2;

   typedef struct {
      logic [2:0]  ev;
      logic [15:0] seq;
      logic [10:0] len;
      logic        last;
   } tx_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] ack_seq
   logic [1:0]  req_tuser = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [15:0] packet_seq, [26:16] data_len
   logic [2:0]  rsp_tuser;        // [2:0] event_res
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sliding_window_sender #(
      .WINDOW_SLOTS (SLOTS),
      .PAYLOAD_BYTES(FULL_LEN)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shared run state. When calm is set neither side idles; hold_request asks
   // the receiver process for one long stall.
   bit           calm = 1'b0;
   bit           hold_request = 1'b0;
   int           hold_left = 0;
   int           mismatches = 0;
   int unsigned  cycle_count = 0;
   tx_event_type events_due[$];
   tx_event_type step_events[$];

   // Private copy of the sender: register values and window state as they
   // stand after every accepted request beat.
   int               cfg_count    = 1;
   int               cfg_last_len = 1024;
   int               cfg_timeout  = 100;
   logic [1:0]       win_phase    = PH_CLOSED;
   int               win_base     = 0;
   logic [SLOTS-1:0] win_acked    = '0;
   logic [SLOTS-1:0] win_running  = '0;
   int               win_age [SLOTS];

   initial begin
      forever #1 clock = ~clock;
   end

   // The run is bounded by a plain cycle counter.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sliding_window_sender_tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40)
         $display("[%0t] %s", $time, what);
   endtask

   // ------------------------------------------------------------------
   // Window model
   // ------------------------------------------------------------------

   task automatic clear_window();
      win_base    = 0;
      win_acked   = '0;
      win_running = '0;
      foreach (win_age[i])
         win_age[i] = 0;
   endtask

   // The final packet carries the configured length, every other a full one.
   function automatic int len_for(input int s);
      if (cfg_count != 0 && s == cfg_count - 1)
         return cfg_last_len;
      return FULL_LEN & 'h7FF;
   endfunction

   task automatic note_event(input logic [2:0] ev, input int s, input int len);
      tx_event_type e;
      e.ev   = ev;
      e.seq  = s[15:0];
      e.len  = len[10:0];
      e.last = 1'b0;
      step_events.push_back(e);
   endtask

   task automatic start_packet(input int s);
      win_running[s % SLOTS] = 1'b1;
      win_age[s % SLOTS]     = 0;
      note_event(EV_SEND, s, len_for(s));
   endtask

   // Advances the model by one request beat and queues the beats it owes.
   task automatic apply_item_to_window(input logic [1:0] kind, input logic [15:0] seq);
      int   s_ack;
      int   b;
      int   bslot;
      int   s;
      logic sliding;
      step_events.delete();
      s_ack = seq;
      case (kind)
         OP_START: begin
            clear_window();
            win_phase = PH_HANDSHK;
            note_event(EV_HANDSHAKE, cfg_count, 0);
         end
         OP_ACK: begin
            if (win_phase == PH_HANDSHK) begin
               note_event(EV_EARLY, s_ack, 0);
            end else if (win_phase == PH_TRANSFER && s_ack < cfg_count &&
                         s_ack >= win_base && s_ack < win_base + SLOTS &&
                         !win_acked[s_ack % SLOTS]) begin
               win_acked[s_ack % SLOTS] = 1'b1;
               // Slide over the run of acked slots at the base; each step
               // admits one new packet at the top of the window, if any is left.
               sliding = 1'b1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (sliding) begin
                     b = win_base % SLOTS;
                     if (!win_acked[b]) begin
                        sliding = 1'b0;
                     end else begin
                        win_acked[b]   = 1'b0;
                        win_running[b] = 1'b0;
                        win_age[b]     = 0;
                        if (win_base + SLOTS < cfg_count)
                           start_packet(win_base + SLOTS);
                        win_base++;
                     end
                  end
               end
               if (win_base == cfg_count) begin
                  win_phase = PH_CLOSED;
                  note_event(EV_DONE, cfg_count, 0);
               end
            end
         end
         OP_HSDONE: begin
            if (win_phase != PH_CLOSED) begin
               clear_window();
               win_phase = PH_TRANSFER;
               for (int i = 0; i < SLOTS && i < cfg_count; i++)
                  start_packet(i);
            end
         end
         OP_TICK: begin
            // Age every running slot; those past the timeout are resent in
            // ascending slot order, acked-but-not-slid ones included.
            if (win_phase != PH_CLOSED) begin
               bslot = win_base % SLOTS;
               for (int i = 0; i < SLOTS; i++) begin
                  if (win_running[i]) begin
                     if (win_age[i] < 'hFFFF)
                        win_age[i]++;
                     if (win_age[i] > cfg_timeout) begin
                        s = win_base + (i + SLOTS - bslot) % SLOTS;
                        win_age[i] = 0;
                        note_event(EV_RESEND, s, len_for(s));
                     end
                  end
               end
            end
         end
      endcase
      if (step_events.size() > 0)
         step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i])
         events_due.push_back(step_events[i]);
   endtask

   // ------------------------------------------------------------------
   // Drivers. Inputs change on the falling edge; every task starts and ends
   // just after a falling edge.
   // ------------------------------------------------------------------

   task automatic send_item(input logic [1:0] kind, input logic [15:0] seq);
      if (!calm)
         while ($urandom_range(99) < 27)
            @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = seq;
      // The beat is taken at the first rising edge that also sees tready.
      do
         @(posedge clock);
      while (!req_tready);
      apply_item_to_window(kind, seq);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_reg(input logic [1:0] index, input int value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value[15:0];
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         REG_PACKET_COUNT: cfg_count    = value & 'hFFFF;
         REG_LAST_LEN:     cfg_last_len = value & 'h7FF;
         REG_TIMEOUT:      cfg_timeout  = value & 'hFFFF;
         default: ;
      endcase
   endtask

   task automatic write_settings(input int count, input int last_len, input int timeout);
      write_reg(REG_PACKET_COUNT, count);
      write_reg(REG_LAST_LEN, last_len);
      write_reg(REG_TIMEOUT, timeout);
   endtask

   // Waits for every owed beat, then lets silent items drain from the queue.
   task automatic wait_idle();
      while (events_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Receiver. Normally drops tready at random with a chance of 27 in a hundred; a hold
   // request keeps tready low for a long stretch so that the block backs up and
   // stops taking request beats.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = calm || ($urandom_range(99) >= 27);
         end
      end
   end

   // Result checker: every accepted beat is compared with the oldest
   // expectation, field by field, padding bits of tdata included.
   always @(posedge clock) begin : check_results
      tx_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (events_due.size() == 0) begin
            report_mismatch($sformatf("beat with nothing owed: event %0d seq %0d",
                                      rsp_tuser, rsp_tdata[15:0]));
         end else begin
            want = events_due.pop_front();
            if (rsp_tuser !== want.ev)
               report_mismatch($sformatf("event %0d, want %0d (seq %0d)",
                                         rsp_tuser, want.ev, want.seq));
            if (rsp_tdata[15:0] !== want.seq)
               report_mismatch($sformatf("packet_seq %0d, want %0d",
                                         rsp_tdata[15:0], want.seq));
            if (rsp_tdata[26:16] !== want.len)
               report_mismatch($sformatf("data_len %0d, want %0d (seq %0d)",
                                         rsp_tdata[26:16], want.len, want.seq));
            if (rsp_tdata[31:27] !== 5'd0)
               report_mismatch($sformatf("tdata padding %b not zero", rsp_tdata[31:27]));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("tlast %b, want %b (seq %0d)",
                                         rsp_tlast, want.last, want.seq));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Register defaults: one packet of 1024 bytes. Items while closed are
   // ignored, acks while handshaking come back as early acks.
   task automatic test_closed_and_handshake();
      send_item(OP_TICK, 16'h0000);
      send_item(OP_ACK, 16'h0000);
      send_item(OP_HSDONE, 16'hFFFF);
      send_item(OP_START, 16'hFFFF);
      send_item(OP_ACK, 16'hFFFF);
      send_item(OP_HSDONE, 16'h0000);
      send_item(OP_ACK, 16'h0001);     // at packet_count, dropped
      send_item(OP_ACK, 16'h0000);     // completes the transfer
      wait_idle();
   endtask

   // Zero packets, then the largest count with the shortest last packet and
   // the shortest timeout: out-of-order, duplicate, stale and far acks,
   // resends with an unaligned base, and a restart while transferring.
   task automatic test_window_edges();
      write_reg(REG_PACKET_COUNT, 0);
      send_item(OP_START, 16'h5A5A);
      send_item(OP_HSDONE, 16'hA5A5);
      send_item(OP_ACK, 16'h0000);
      wait_idle();
      write_settings(65535, 1, 1);
      send_item(OP_START, 16'h0000);
      send_item(OP_HSDONE, 16'h0000);
      send_item(OP_ACK, 16'd3);
      send_item(OP_ACK, 16'd3);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_TICK, 16'hFFFF);
      send_item(OP_ACK, 16'd0);
      send_item(OP_ACK, 16'd2);
      send_item(OP_ACK, 16'd1);
      send_item(OP_ACK, 16'd0);        // below the base now
      send_item(OP_ACK, 16'd12);       // one past the top of the window
      send_item(OP_ACK, 16'hFFFF);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_HSDONE, 16'h0000);
      wait_idle();
   endtask

   // The receiver stalls for a long stretch while ticks keep resending the
   // whole window, so the command queue fills and req_tready drops.
   task automatic test_output_backpressure();
      write_settings(40, 17, 1);
      send_item(OP_START, 16'h0000);
      send_item(OP_HSDONE, 16'h0000);
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++)
         send_item(OP_TICK, 16'($urandom));
      for (int i = 0; i < 4; i++)
         send_item(OP_ACK, 16'(i));
      wait_idle();
   endtask

   // One transfer from start to completion or until the item allowance runs
   // out. Mostly in-window acks and ticks, with some noise and restarts.
   task automatic run_one_transfer(inout int left);
      int r;
      send_item(OP_START, 16'($urandom));
      left--;
      if ($urandom_range(99) < 20) begin
         send_item(OP_ACK, 16'($urandom));
         left--;
      end
      send_item(OP_HSDONE, 16'($urandom));
      left--;
      while (left > 0 && win_phase != PH_CLOSED) begin
         r = $urandom_range(99);
         if (win_phase == PH_HANDSHK) begin
            if (r < 30)
               send_item(OP_ACK, 16'($urandom));
            else
               send_item(OP_HSDONE, 16'($urandom));
         end else if (r < 55) begin
            send_item(OP_ACK, 16'(win_base + $urandom_range(SLOTS - 1)));
         end else if (r < 82) begin
            send_item(OP_TICK, 16'($urandom));
         end else if (r < 88) begin
            send_item(OP_ACK, 16'($urandom));
         end else if (r < 92) begin
            send_item(OP_ACK, 16'(win_base - 1 - $urandom_range(3)));
         end else if (r < 95) begin
            send_item(OP_ACK, 16'(win_base + SLOTS + $urandom_range(3)));
         end else if (r < 98) begin
            send_item(OP_HSDONE, 16'($urandom));
         end else begin
            send_item(OP_START, 16'($urandom));
         end
         left--;
      end
   endtask

   // Random transfers over a rotation of register settings, the extremes
   // among them. One setting runs with no idling on either side.
   task automatic test_random_transfers();
      int budget;
      int share;
      int k;
      budget = 272;
      k      = 0;
      while (budget > 0) begin
         wait_idle();
         case (k % 7)
            0: write_settings(1, 1024, 1);
            1: write_settings(9, 1, 2);
            2: write_settings($urandom_range(24, 2), $urandom_range(1024, 1),
                              $urandom_range(6, 1));
            3: write_settings(65535, $urandom_range(1024, 1), 65535);
            4: write_settings(8, $urandom_range(1024, 1), 3);
            5: write_settings($urandom_range(30, 10), 1024, $urandom_range(4, 1));
            default: write_settings($urandom_range(16, 1), $urandom_range(1024, 1), 1);
         endcase
         calm  = (k == 4);
         share = (budget < 48) ? budget : 48;
         budget -= share;
         while (share > 0)
            run_one_transfer(share);
         k++;
      end
      calm = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_closed_and_handshake();
      test_window_edges();
      test_output_backpressure();
      test_random_transfers();
      wait_idle();
      if (mismatches == 0 && events_due.size() == 0)
         $display("sliding_window_sender_tb passed");
      else
         $display("sliding_window_sender_tb failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/swsnd_pkg.sv
rtl/swsnd_front.sv
rtl/swsnd_cmdq.sv
rtl/swsnd_back.sv
rtl/sliding_window_sender.sv
tb/sv/sliding_window_sender_tb.sv
